[src/mset_pkg.sv]
// ----------------------------------------------------------------------------
// mset_pkg
// Shared types and constants for the multi-slot event timer.
// ----------------------------------------------------------------------------
package mset_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TMR_W         = 32;
	localparam int RES_SLOT_W    = 5;
	localparam int MAX_RESULTS   = 16;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

	typedef logic [RES_SLOT_W-1:0] res_slot_t;
	typedef logic [TMR_W-1:0]      tmr_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_CONN  = 2'd1,
		REQ_START = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK_RD,
		S_TICK_EX,
		S_FLUSH,
		S_CONN,
		S_OP_RD,
		S_OP_EX
	} state_t;

endpackage

[src/mset_ram.sv]
// ----------------------------------------------------------------------------
// mset_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module mset_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/mset_alloc.sv]
// ----------------------------------------------------------------------------
// mset_alloc
// Finds the lowest-numbered free slot for a connect request.
// ----------------------------------------------------------------------------
module mset_alloc #(
	parameter  int NUM_SLOTS = 16,
	localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic [NUM_SLOTS-1:0] used,
	output logic                 found,
	output logic [SW-1:0]        idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		// scan downward so the lowest free slot wins
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				found = 1'b1;
				idx   = SW'(i);
			end
		end
	end

endmodule

[src/multi_slot_event_timer.sv]
// ----------------------------------------------------------------------------
// multi_slot_event_timer
// Bank of one-shot / periodic timer slots; counts and reload values in RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------
//  in      | req_type, slot_id, interval, periodic     | in_valid / in_ready
//  out     | result_slot, fired, last                  | out_valid / out_ready
//
//  Sequencing: one item at a time. A tick passes the accept state, a read
//  state per slot, an execute state per armed slot (decrement and write
//  back after the RAM read), then a flush state. Connect passes the accept
//  and connect states; start and stop read the reload value before the write.
//  Reset: slot flags clear at once; the RAMs need no clearing pass, every
//  entry is written before its value is used.
//  Stalls: a full output register holds the walk where the next result waits.
// ----------------------------------------------------------------------------
module multi_slot_event_timer #(
	parameter  int NUM_SLOTS = mset_pkg::NUM_SLOTS_DEF,
	localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    slot_id,
	input  logic [31:0]                   interval,
	input  logic                          periodic,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mset_pkg::RES_SLOT_W-1:0] result_slot,
	output logic                          fired,
	output logic                          last
);

	import mset_pkg::*;

	state_t               state_q, state_d;
	logic [SW-1:0]        slot_idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_valid_q;
	res_slot_t            pend_slot_q;
	logic [NUM_SLOTS-1:0] conn_q, act_q, perd_q;

	req_t                 req_q;
	logic [7:0]           sid_q;
	tmr_t                 ivl_q;
	logic                 mode_q;

	logic                 out_valid_q, fired_q, last_q;
	res_slot_t            res_slot_q;

	// RAM ports
	logic                 rem_re, rem_we, rld_re, rld_we;
	logic [SW-1:0]        raddr, rem_waddr, rld_waddr;
	tmr_t                 rem_wdata, rld_wdata, rem_rdata, rld_rdata;

	logic                 free_found;
	logic [SW-1:0]        free_idx;

	logic                 can_push, last_slot, armed, expire, record, ex_stall;
	logic                 id_ok, op_ok;
	logic [SW-1:0]        op_idx;
	logic [SW:0]          walk_id, conn_id;
	tmr_t                 rem_dec;
	logic                 push, push_fired, push_last;
	res_slot_t            push_slot;

	mset_alloc #(.NUM_SLOTS(NUM_SLOTS)) u_alloc (
		.used  (conn_q),
		.found (free_found),
		.idx   (free_idx)
	);

	mset_ram #(.WIDTH(TMR_W), .DEPTH(NUM_SLOTS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (rem_re),
		.raddr (raddr),
		.rdata (rem_rdata)
	);

	mset_ram #(.WIDTH(TMR_W), .DEPTH(NUM_SLOTS)) u_rld_ram (
		.clk   (clk),
		.we    (rld_we),
		.waddr (rld_waddr),
		.wdata (rld_wdata),
		.re    (rld_re),
		.raddr (raddr),
		.rdata (rld_rdata)
	);

	assign can_push  = !out_valid_q || out_ready;
	assign last_slot = (slot_idx_q == SW'(NUM_SLOTS - 1));
	assign armed     = conn_q[slot_idx_q] && act_q[slot_idx_q];
	assign rem_dec   = rem_rdata - tmr_t'(1);
	assign expire    = (rem_rdata == tmr_t'(1));
	assign record    = expire && (cnt_q < CNT_W'(MAX_RESULTS));
	// a new expiry pushes the previous one out; wait if output is occupied
	assign ex_stall  = record && pend_valid_q && !can_push;
	assign id_ok     = (sid_q != 8'd0) && (sid_q <= 8'(NUM_SLOTS));
	assign op_idx    = SW'(sid_q - 8'd1);
	assign op_ok     = id_ok && conn_q[op_idx];
	assign walk_id   = (SW+1)'(slot_idx_q) + (SW+1)'(1);
	assign conn_id   = (SW+1)'(free_idx) + (SW+1)'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (req_t'(req_type))
						REQ_TICK:             state_d = S_TICK_RD;
						REQ_CONN:             state_d = S_CONN;
						REQ_START, REQ_STOP:  state_d = S_OP_RD;
					endcase
				end
			end
			S_TICK_RD: begin
				if (armed) begin
					state_d = S_TICK_EX;
				end else if (last_slot) begin
					state_d = S_FLUSH;
				end
			end
			S_TICK_EX: begin
				if (!ex_stall) begin
					state_d = last_slot ? S_FLUSH : S_TICK_RD;
				end
			end
			S_FLUSH, S_CONN, S_OP_EX: begin
				if (can_push) begin
					state_d = S_IDLE;
				end
			end
			S_OP_RD: state_d = S_OP_EX;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and RAM control
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		rem_re     = 1'b0;
		rld_re     = 1'b0;
		raddr      = slot_idx_q;
		rem_we     = 1'b0;
		rem_waddr  = slot_idx_q;
		rem_wdata  = rem_dec;
		rld_we     = 1'b0;
		rld_waddr  = free_idx;
		rld_wdata  = ivl_q;
		push       = 1'b0;
		push_slot  = '0;
		push_fired = 1'b0;
		push_last  = 1'b1;
		unique case (state_q)
			S_TICK_RD: begin
				rem_re = armed;
				rld_re = armed;
			end
			S_TICK_EX: begin
				if (!ex_stall) begin
					rem_we     = 1'b1;
					rem_wdata  = (expire && perd_q[slot_idx_q]) ? rld_rdata : rem_dec;
					push       = record && pend_valid_q;
					push_slot  = pend_slot_q;
					push_fired = 1'b1;
					push_last  = 1'b0;
				end
			end
			S_FLUSH: begin
				push       = can_push;
				push_slot  = pend_valid_q ? pend_slot_q : '0;
				push_fired = pend_valid_q;
			end
			S_CONN: begin
				if (can_push) begin
					push      = 1'b1;
					push_slot = free_found ? res_slot_t'(conn_id) : '0;
					rem_we    = free_found;
					rem_waddr = free_idx;
					rem_wdata = mode_q ? ivl_q : '0;
					rld_we    = free_found;
				end
			end
			S_OP_RD: begin
				rld_re = 1'b1;
				raddr  = op_idx;
			end
			S_OP_EX: begin
				if (can_push) begin
					push      = 1'b1;
					rem_we    = op_ok;
					rem_waddr = op_idx;
					rem_wdata = (req_q == REQ_START) ? rld_rdata : '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			conn_q       <= '0;
			act_q        <= '0;
			perd_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			slot_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						slot_idx_q   <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				S_TICK_RD: begin
					if (!armed && !last_slot) begin
						slot_idx_q <= slot_idx_q + 1'b1;
					end
				end
				S_TICK_EX: begin
					if (!ex_stall) begin
						if (expire && !perd_q[slot_idx_q]) begin
							act_q[slot_idx_q] <= 1'b0;
						end
						if (record) begin
							pend_valid_q <= 1'b1;
							cnt_q        <= cnt_q + 1'b1;
						end
						if (!last_slot) begin
							slot_idx_q <= slot_idx_q + 1'b1;
						end
					end
				end
				S_CONN: begin
					if (can_push && free_found) begin
						conn_q[free_idx] <= 1'b1;
						perd_q[free_idx] <= mode_q;
						act_q[free_idx]  <= mode_q;
					end
				end
				S_OP_EX: begin
					if (can_push && op_ok) begin
						act_q[op_idx] <= (req_q == REQ_START);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= req_t'(req_type);
			sid_q  <= slot_id;
			ivl_q  <= interval;
			mode_q <= periodic;
		end
		if (state_q == S_TICK_EX && !ex_stall && record) begin
			pend_slot_q <= res_slot_t'(walk_id);
		end
		if (push) begin
			res_slot_q <= push_slot;
			fired_q    <= push_fired;
			last_q     <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_slot = res_slot_q;
	assign fired       = fired_q;
	assign last        = last_q;

`ifndef NO_ASSERTIONS
	a_act_needs_conn: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q & ~conn_q) == '0)
		else $error("armed slot is not connected");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("expiry count above cap");

	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> last)
		else $error("non-fired result not marked last");

	a_fired_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired && (NUM_SLOTS < 32) |-> result_slot != '0)
		else $error("fired result with slot id zero");
`endif

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_slot_event_timer. A table of directed requests
// is run first, then random requests in four flow-control phases. Results are
// scored against a slot-bank model in the bench or the answer a row carries.
// ----------------------------------------------------------------------------
module tb_top;
	import mset_pkg::*;

	localparam int SLOTS            = NUM_SLOTS_DEF;
	localparam int RANDOM_PER_PHASE = 84;
	localparam int SETTLE_CYCLES    = 2 * SLOTS + 8;

	typedef struct packed {
		req_t       req;
		logic [7:0] id;
		tmr_t       ivl;
		logic       per;
		logic       typed;  // row carries its own answer
		res_slot_t  slot;
	} request_t;

	typedef struct packed {
		res_slot_t slot;
		logic      fired;
		logic      last;
	} outcome_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [7:0] slot_id;
	logic [31:0] interval;
	logic       periodic;
	logic       out_valid;
	logic       out_ready = 1'b0;
	res_slot_t  result_slot;
	logic       fired;
	logic       last;

	multi_slot_event_timer #(.NUM_SLOTS(SLOTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot_id    (slot_id),
		.interval   (interval),
		.periodic   (periodic),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_slot(result_slot),
		.fired      (fired),
		.last       (last)
	);

	// slot bank as the bench sees it
	bit   slot_conn   [SLOTS];
	bit   slot_armed  [SLOTS];
	bit   slot_repeat [SLOTS];
	tmr_t slot_count  [SLOTS];
	tmr_t slot_reload [SLOTS];

	outcome_t fresh[$];    // results of the request just taken
	outcome_t awaited[$];  // results not yet seen on the output
	int       fail_count = 0;
	int       in_gap_pct;
	int       out_stall_pct;

	int gap_pct_of   [4] = '{0, 50, 0, 9};
	int stall_pct_of [4] = '{0, 0, 50, 9};

	request_t directed_rows [22] = '{
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b1, 5'd0},  // nothing connected
		'{REQ_START, 8'd0,   32'd5,         1'b1, 1'b1, 5'd0},  // id zero
		'{REQ_STOP,  8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0},  // id far out of range
		'{REQ_START, 8'd1,   32'd0,         1'b0, 1'b1, 5'd0},  // slot not connected
		'{REQ_CONN,  8'd0,   32'd1,         1'b1, 1'b1, 5'd1},
		'{REQ_TICK,  8'hA5,  32'h5A5A_5A5A, 1'b1, 1'b0, 5'd0},
		'{REQ_CONN,  8'd9,   32'd2,         1'b0, 1'b1, 5'd2},  // one-shot stays idle
		'{REQ_START, 8'd2,   32'd0,         1'b0, 1'b1, 5'd0},
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_CONN,  8'd0,   32'd0,         1'b1, 1'b1, 5'd3},  // armed with zero count
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_CONN,  8'd255, 32'hFFFF_FFFF, 1'b0, 1'b1, 5'd4},
		'{REQ_START, 8'd4,   32'd0,         1'b0, 1'b1, 5'd0},
		'{REQ_START, 8'd17,  32'd0,         1'b0, 1'b1, 5'd0},  // just past the bank
		'{REQ_STOP,  8'd1,   32'd0,         1'b0, 1'b1, 5'd0},
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_START, 8'd1,   32'd0,         1'b0, 1'b1, 5'd0},
		'{REQ_STOP,  8'd3,   32'd0,         1'b0, 1'b1, 5'd0},
		'{REQ_TICK,  8'd0,   32'd0,         1'b0, 1'b0, 5'd0},
		'{REQ_CONN,  8'hFF,  32'd3,         1'b1, 1'b1, 5'd5}
	};

	// Updates the slot bank for one request and leaves its results in fresh.
	function automatic void apply_request(input request_t r);
		outcome_t  o;
		int        n;
		int        s;
		res_slot_t got;
		fresh.delete();
		n   = 0;
		got = '0;
		case (r.req)
			REQ_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_conn[i] && slot_armed[i]) begin
						slot_count[i] = slot_count[i] - 1'b1;
						if (slot_count[i] == '0) begin
							if (n < MAX_RESULTS) begin
								o = '{res_slot_t'(i + 1), 1'b1, 1'b0};
								fresh.push_back(o);
								n++;
							end
							if (slot_repeat[i])
								slot_count[i] = slot_reload[i];
							else
								slot_armed[i] = 1'b0;
						end
					end
				end
				if (n == 0) begin
					o = '{'0, 1'b0, 1'b1};
					fresh.push_back(o);
				end else begin
					fresh[fresh.size() - 1].last = 1'b1;
				end
			end
			REQ_CONN: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_conn[i]) begin
						slot_conn[i]   = 1'b1;
						slot_repeat[i] = r.per;
						slot_armed[i]  = r.per;
						slot_count[i]  = r.per ? r.ivl : '0;
						slot_reload[i] = r.ivl;
						got            = res_slot_t'(i + 1);
						break;
					end
				end
				o = '{got, 1'b0, 1'b1};
				fresh.push_back(o);
			end
			default: begin
				if (r.id >= 1 && r.id <= SLOTS) begin
					s = r.id - 1;
					if (slot_conn[s]) begin
						if (r.req == REQ_START) begin
							slot_armed[s] = 1'b1;
							slot_count[s] = slot_reload[s];
						end else begin
							slot_armed[s] = 1'b0;
							slot_count[s] = '0;
						end
					end
				end
				o = '{'0, 1'b0, 1'b1};
				fresh.push_back(o);
			end
		endcase
	endfunction

	function automatic tmr_t pick_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 6);
		else if (r < 90)
			return $urandom_range(7, 60);
		return $urandom;
	endfunction

	// Connects mostly while the bank has room, among tick/start/stop traffic, some with bad ids.
	function automatic request_t random_request();
		request_t r;
		int       pick;
		bit       full;
		r.id    = 8'($urandom_range(0, 255));
		r.ivl   = $urandom;
		r.per   = 1'($urandom_range(0, 1));
		r.typed = 1'b0;
		r.slot  = '0;
		full = 1'b1;
		foreach (slot_conn[i])
			if (!slot_conn[i])
				full = 1'b0;
		pick = $urandom_range(0, 99);
		if (!full && pick < 35) begin
			r.req = REQ_CONN;
			r.ivl = pick_interval();
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				r.req = REQ_TICK;
			end else if (pick < 72) begin
				r.req = REQ_START;
				r.id  = 8'($urandom_range(1, SLOTS));
			end else if (pick < 84) begin
				r.req = REQ_STOP;
				r.id  = 8'($urandom_range(1, SLOTS));
			end else if (pick < 94) begin
				r.req = $urandom_range(0, 1) ? REQ_START : REQ_STOP;
				r.id  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(SLOTS + 1, 255));
			end else begin
				r.req = REQ_CONN;  // usually finds the bank full
			end
		end
		return r;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_request(input request_t r);
		outcome_t o;
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		slot_id  <= r.id;
		interval <= r.ivl;
		periodic <= r.per;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_request(r);
		if (r.typed) begin
			o = '{r.slot, 1'b0, 1'b1};
			awaited.push_back(o);
		end else begin
			foreach (fresh[k])
				awaited.push_back(fresh[k]);
		end
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
	end

	always @(posedge clk) begin : score
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected item slot=%0d fired=%0b last=%0b",
					$time, result_slot, fired, last);
				fail_count++;
			end else begin
				want = awaited.pop_front();
				if (result_slot !== want.slot) begin
					$display("%0t: result_slot expected %0d got %0d",
						$time, want.slot, result_slot);
					fail_count++;
				end
				if (fired !== want.fired) begin
					$display("%0t: fired expected %0b got %0b", $time, want.fired, fired);
					fail_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_TICK;
		slot_id       = '0;
		interval      = '0;
		periodic      = 1'b0;
		in_gap_pct    = 0;
		out_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[k])
			send_request(directed_rows[k]);
		for (int p = 0; p < 4; p++) begin
			in_gap_pct    = gap_pct_of[p];
			out_stall_pct = stall_pct_of[p];
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				send_request(random_request());
			// hold off until the bank has answered everything
			in_valid <= 1'b0;
			while (awaited.size() != 0)
				@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
